/* hw/rtl/masked_hamming_membership_assert.svh */
// ----------------------------------------------------------------------------
// Masked Hamming membership: assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_HAMMING_MEMBERSHIP_ASSERT_SVH
`define MASKED_HAMMING_MEMBERSHIP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MHM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MHM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mhm_pkg.sv */
// ----------------------------------------------------------------------------
// Masked Hamming membership package
// Field widths, register codes and the byte popcount shared by the block.
// ----------------------------------------------------------------------------
package mhm_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned THR_W       = 8;
  localparam int unsigned TPU_W       = 7;
  localparam int unsigned GRP_W       = 6;
  localparam int unsigned THR_SHIFT   = 7;
  localparam int unsigned IN_TDATA_W  = 4 * WORD_W;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [THR_W-1:0] THR_RESET = 8'd52;
  localparam logic [TPU_W-1:0] TPU_RESET = 7'd1;
  localparam logic [TPU_W-1:0] TPU_MIN   = 7'd1;
  localparam logic [TPU_W-1:0] TPU_MAX   = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_TPU       = 1'b1
  } cfg_idx_e;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

endpackage

/* hw/rtl/masked_hamming_membership.sv */
// ----------------------------------------------------------------------------
// Masked Hamming membership matcher
// Streams template chunks against a query, accumulates masked distance and
// valid-bit counts, judges each template against a fractional threshold and
// fuses templates into users and users into a membership flag.
// ----------------------------------------------------------------------------
//
//  channel   | dir | data fields (low bit up)                         | side
//  ----------+-----+--------------------------------------------------+---------------
//  s_axis    | in  | ref_bits, ref_valid, query_bits, query_valid     | tlast=last_chunk
//            |     |                                                  | tuser=last_template
//  m_axis    | out | distance, valid_count, template_match, user_done,| tlast=db_done
//            |     | user_match, membership, 2 pad bits               |
//  cfg       | in  | cfg_we_i, cfg_idx_i (0 threshold, 1 tpu), data   | -
//
//  One chunk is taken every cycle unless output stalls have filled the stages;
//  a result passes mask, popcount, accumulate and judge after the accept of
//  its template's last chunk. The accumulate stage sets the rate: one add per chunk.
//  Reset clears all pipeline valids, accumulators and group state and loads
//  the register defaults. A stalled result holds in the output register while
//  the stages behind it keep filling, so input stalls only once all are full.
// ----------------------------------------------------------------------------
module masked_hamming_membership
  import mhm_pkg::*;
#(
  parameter int unsigned CHUNK_BITS        = 64,
  parameter int unsigned MAX_TEMPLATE_BITS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // ref_bits, ref_valid, query_bits, query_valid
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // last_template
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // distance, valid_count, template_match, user_done, user_match,
  // membership, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [THR_W-1:0]       cfg_data_i
);

  localparam int unsigned POP_W  = $clog2(CHUNK_BITS + 1);
  localparam int unsigned ACC_W  = $clog2(MAX_TEMPLATE_BITS + 1);
  localparam int unsigned NLANE  = (CHUNK_BITS + 7) / 8;
  localparam int unsigned PAD_W  = NLANE * 8;
  localparam int unsigned WIDE_W = (ACC_W > CNT_W) ? ACC_W : CNT_W;
  localparam int unsigned PROD_W = ACC_W + THR_W;
  localparam int unsigned LIM_W  = PROD_W - THR_SHIFT;
  localparam logic [ACC_W:0] SAT_MAX = (ACC_W + 1)'(MAX_TEMPLATE_BITS);

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [TPU_W-1:0] tpu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      tpu_q <= TPU_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_TPU:       tpu_q <= cfg_data_i[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s2_lc_q;
  logic adv1, adv2, adv3, adv4, s2_take;

  assign adv4    = !s4_vld_q || m_axis_tready;
  assign adv3    = !s3_vld_q || adv4;
  // a chunk that does not end a template only feeds the accumulators
  assign s2_take = !s2_lc_q || adv3;
  assign adv2    = !s2_vld_q || s2_take;
  assign adv1    = !s1_vld_q || adv2;

  assign s_axis_tready = adv1;

  // ---- stage 1: masked difference and valid vectors ----
  logic [CHUNK_BITS-1:0] s1_diff_q, s1_mask_q;
  logic                  s1_lc_q, s1_lt_q;
  logic [WORD_W-1:0]     in_ref, in_refv, in_qry, in_qryv, in_mask, in_diff;

  assign in_ref  = s_axis_tdata[0*WORD_W +: WORD_W];
  assign in_refv = s_axis_tdata[1*WORD_W +: WORD_W];
  assign in_qry  = s_axis_tdata[2*WORD_W +: WORD_W];
  assign in_qryv = s_axis_tdata[3*WORD_W +: WORD_W];
  assign in_mask = in_refv & in_qryv;
  assign in_diff = (in_ref ^ in_qry) & in_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv1) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      s1_mask_q <= in_mask[CHUNK_BITS-1:0];
      s1_diff_q <= in_diff[CHUNK_BITS-1:0];
      s1_lc_q   <= s_axis_tlast;
      s1_lt_q   <= s_axis_tuser;
    end
  end

  // ---- stage 2: popcounts, byte lanes then lane sum ----
  logic [PAD_W-1:0] diff_pad, mask_pad;
  logic [POP_W-1:0] dpop, vpop;
  logic [POP_W-1:0] s2_dpop_q, s2_vpop_q;
  logic             s2_lt_q;

  assign diff_pad = PAD_W'(s1_diff_q);
  assign mask_pad = PAD_W'(s1_mask_q);

  always_comb begin
    dpop = '0;
    vpop = '0;
    for (int l = 0; l < NLANE; l++) begin
      dpop = dpop + POP_W'(popcnt8(diff_pad[l*8 +: 8]));
      vpop = vpop + POP_W'(popcnt8(mask_pad[l*8 +: 8]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s2_lc_q  <= 1'b0;
    end else if (adv2) begin
      s2_vld_q <= s1_vld_q;
      s2_lc_q  <= s1_vld_q && s1_lc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_vld_q) begin
      s2_dpop_q <= dpop;
      s2_vpop_q <= vpop;
      s2_lt_q   <= s1_lt_q;
    end
  end

  // ---- stage 3: saturating accumulate, latch totals at template end ----
  logic [ACC_W-1:0] dist_acc_q, valid_acc_q;
  logic [ACC_W:0]   dsum, vsum;
  logic [ACC_W-1:0] dsat, vsat;
  logic [ACC_W-1:0] s3_dist_q, s3_valid_q;
  logic             s3_lt_q;

  assign dsum = {1'b0, dist_acc_q} + (ACC_W + 1)'(s2_dpop_q);
  assign vsum = {1'b0, valid_acc_q} + (ACC_W + 1)'(s2_vpop_q);
  assign dsat = (dsum > SAT_MAX) ? SAT_MAX[ACC_W-1:0] : dsum[ACC_W-1:0];
  assign vsat = (vsum > SAT_MAX) ? SAT_MAX[ACC_W-1:0] : vsum[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_acc_q  <= '0;
      valid_acc_q <= '0;
      s3_vld_q    <= 1'b0;
    end else begin
      if (s2_vld_q && s2_take) begin
        // restart at each template end
        dist_acc_q  <= s2_lc_q ? '0 : dsat;
        valid_acc_q <= s2_lc_q ? '0 : vsat;
      end
      if (adv3) begin
        s3_vld_q <= s2_vld_q && s2_lc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_vld_q && s2_lc_q) begin
      s3_dist_q  <= dsat;
      s3_valid_q <= vsat;
      s3_lt_q    <= s2_lt_q;
    end
  end

  // ---- stage 4: threshold, user grouping, membership ----
  logic [PROD_W-1:0] prod;
  logic [LIM_W-1:0]  limit;
  logic              match;
  logic [TPU_W-1:0]  tpu_eff;
  logic              done, and_new, umatch, member_new;
  logic              grp_and_q, member_or_q;
  logic [GRP_W-1:0]  grp_cnt_q;
  logic [WIDE_W-1:0] dist_wide, valid_wide;

  assign prod  = PROD_W'(s3_valid_q) * PROD_W'(thr_q);
  assign limit = prod[PROD_W-1:THR_SHIFT];
  assign match = LIM_W'(s3_dist_q) < limit;

  always_comb begin
    tpu_eff = tpu_q;
    if (tpu_q < TPU_MIN) begin
      tpu_eff = TPU_MIN;
    end else if (tpu_q > TPU_MAX) begin
      tpu_eff = TPU_MAX;
    end
  end

  assign done       = ({1'b0, grp_cnt_q} + TPU_W'(1)) >= tpu_eff;
  assign and_new    = grp_and_q & match;
  assign umatch     = done & and_new;
  assign member_new = member_or_q | umatch;

  assign dist_wide  = WIDE_W'(s3_dist_q);
  assign valid_wide = WIDE_W'(s3_valid_q);

  logic s4_fire;
  assign s4_fire = s3_vld_q && adv4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q    <= 1'b0;
      grp_and_q   <= 1'b1;
      grp_cnt_q   <= '0;
      member_or_q <= 1'b0;
    end else begin
      if (adv4) begin
        s4_vld_q <= s3_vld_q;
      end
      if (s4_fire) begin
        if (s3_lt_q) begin
          // database end: start the next run clean, partial group dropped
          grp_and_q   <= 1'b1;
          grp_cnt_q   <= '0;
          member_or_q <= 1'b0;
        end else begin
          member_or_q <= member_new;
          if (done) begin
            grp_and_q <= 1'b1;
            grp_cnt_q <= '0;
          end else begin
            grp_and_q <= and_new;
            grp_cnt_q <= grp_cnt_q + GRP_W'(1);
          end
        end
      end
    end
  end

  logic [CNT_W-1:0] out_dist_q, out_valid_q;
  logic             out_match_q, out_done_q, out_umatch_q, out_member_q, out_db_q;

  always_ff @(posedge clk_i) begin
    if (s4_fire) begin
      out_dist_q   <= dist_wide[CNT_W-1:0];
      out_valid_q  <= valid_wide[CNT_W-1:0];
      out_match_q  <= match;
      out_done_q   <= done;
      out_umatch_q <= umatch;
      out_member_q <= member_new;
      out_db_q     <= s3_lt_q;
    end
  end

  assign m_axis_tvalid = s4_vld_q;
  assign m_axis_tlast  = out_db_q;
  assign m_axis_tdata  = {2'b00, out_member_q, out_umatch_q, out_done_q, out_match_q,
                          out_valid_q, out_dist_q};

endmodule

/* hw/rtl/mhm_checker.sv */
// ----------------------------------------------------------------------------
// Masked Hamming membership port checker
// Watches the result stream for stall-hold and consistency slips.
// ----------------------------------------------------------------------------
`include "masked_hamming_membership_assert.svh"

module mhm_checker
  import mhm_pkg::*;
#(
  parameter int unsigned MAX_TEMPLATE_BITS = 4096
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  // counts are exact in 13 bits only below this size
  localparam bit EXACT = MAX_TEMPLATE_BITS < 8192;

  logic [CNT_W-1:0] o_dist, o_valid;
  logic             o_match, o_done, o_umatch, o_member;

  assign o_dist   = m_axis_tdata[CNT_W-1:0];
  assign o_valid  = m_axis_tdata[2*CNT_W-1:CNT_W];
  assign o_match  = m_axis_tdata[2*CNT_W];
  assign o_done   = m_axis_tdata[2*CNT_W+1];
  assign o_umatch = m_axis_tdata[2*CNT_W+2];
  assign o_member = m_axis_tdata[2*CNT_W+3];

  `MHM_ASSERT_NXT(a_hold_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed in stall")
  `MHM_ASSERT_IMP(a_umatch_done, clk_i, rst_ni, m_axis_tvalid && o_umatch,
    o_done && o_member, "user match without group end or membership")
  `MHM_ASSERT_IMP(a_dist_le_valid, clk_i, rst_ni, EXACT && m_axis_tvalid,
    o_dist <= o_valid, "distance above valid count")
  `MHM_ASSERT_IMP(a_empty_nomatch, clk_i, rst_ni, EXACT && m_axis_tvalid && o_valid == '0,
    !o_match, "match with no valid bits")

endmodule

bind masked_hamming_membership mhm_checker #(
  .MAX_TEMPLATE_BITS(MAX_TEMPLATE_BITS)
) u_mhm_checker (.*);

/* test/masked_hamming_membership_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked Hamming membership testbench
// Streams directed and random template chunks against the matcher, predicts
// every template verdict in a scoreboard and compares each output word field
// by field, under several register settings and handshake pacing modes.
// ----------------------------------------------------------------------------
module masked_hamming_membership_tb;
  import mhm_pkg::*;

  localparam int unsigned MAX_BITS  = 4096;
  localparam int          DRAIN     = 12;
  localparam int          LONG_HOLD = 300;
  localparam int          N_PHASES  = 8;
  localparam int          PHASE_LEN = 120;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [WORD_W-1:0] ref_bits;
    logic [WORD_W-1:0] ref_valid;
    logic [WORD_W-1:0] query_bits;
    logic [WORD_W-1:0] query_valid;
    logic              last_chunk;
    logic              last_template;
  } chunk_t;

  typedef struct packed {
    logic [CNT_W-1:0] distance;
    logic [CNT_W-1:0] valid_count;
    logic             template_match;
    logic             user_done;
    logic             user_match;
    logic             membership;
    logic             db_done;
  } verdict_t;

  typedef enum int {STYLE_RANDOM, STYLE_NEAR, STYLE_LOOSE, STYLE_INVERT} code_style_e;

  class hamming_scoreboard;
    logic [THR_W-1:0] thr;
    logic [TPU_W-1:0] tpu;
    int unsigned      dist_acc, valid_acc, group_count;
    bit               group_and, member_or;
    verdict_t         verdicts[$];
    int unsigned      errors, n_chunks, n_templates, n_users, n_dbs, n_sat, n_hits;

    function new();
      thr = THR_RESET;
      tpu = TPU_RESET;
      clear_run();
    endfunction

    function void clear_run();
      dist_acc    = 0;
      valid_acc   = 0;
      group_and   = 1'b1;
      group_count = 0;
      member_or   = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [THR_W-1:0] val);
      if (idx == CFG_THRESHOLD) begin
        thr = val;
      end else begin
        tpu = val[TPU_W-1:0];
      end
    endfunction

    function int unsigned clip(int unsigned v);
      return (v > MAX_BITS) ? MAX_BITS : v;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_chunk(chunk_t c);
      logic [WORD_W-1:0] both, diff;
      int unsigned       limit, eff_tpu;
      verdict_t          v;
      both = c.ref_valid & c.query_valid;
      diff = (c.ref_bits ^ c.query_bits) & both;
      n_chunks++;
      dist_acc  = clip(dist_acc + $countones(diff));
      valid_acc = clip(valid_acc + $countones(both));
      if (!c.last_chunk) return;

      limit = (valid_acc * int'(thr)) >> THR_SHIFT;
      eff_tpu = tpu;
      if (eff_tpu < TPU_MIN) eff_tpu = TPU_MIN;
      if (eff_tpu > TPU_MAX) eff_tpu = TPU_MAX;

      v.distance       = dist_acc[CNT_W-1:0];
      v.valid_count    = valid_acc[CNT_W-1:0];
      v.template_match = (dist_acc < limit);
      group_and        = group_and & v.template_match;
      v.user_done      = (group_count + 1 >= eff_tpu);
      v.user_match     = v.user_done & group_and;
      if (v.user_done) begin
        member_or   = member_or | v.user_match;
        group_and   = 1'b1;
        group_count = 0;
        n_users++;
      end else begin
        group_count = (group_count + 1) & ((1 << GRP_W) - 1);
      end
      v.membership = member_or;
      v.db_done    = c.last_template;
      verdicts.push_back(v);

      n_templates++;
      if (v.template_match) n_hits++;
      if (dist_acc == MAX_BITS || valid_acc == MAX_BITS) n_sat++;
      dist_acc  = 0;
      valid_acc = 0;
      if (c.last_template) begin
        clear_run();
        n_dbs++;
      end
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic last);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result word %h arrived with no verdict pending", d);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      compare("distance",       v.distance,       d[CNT_W-1:0]);
      compare("valid_count",    v.valid_count,    d[2*CNT_W-1:CNT_W]);
      compare("template_match", v.template_match, d[2*CNT_W]);
      compare("user_done",      v.user_done,      d[2*CNT_W+1]);
      compare("user_match",     v.user_match,     d[2*CNT_W+2]);
      compare("membership",     v.membership,     d[2*CNT_W+3]);
      compare("db_done",        v.db_done,        last);
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  // ref_bits, ref_valid, query_bits, query_valid
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  // last_template
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // distance, valid_count, template_match, user_done, user_match,
  // membership, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [THR_W-1:0]       cfg_data_i    = '0;

  hamming_scoreboard sb;
  chunk_t            stim_q[$];
  int                src_idle_pct   = 0;
  int                sink_stall_pct = 0;
  int                hold_asked     = 0;
  int                hold_seen      = 0;
  int                hold_left      = 0;
  int                n_settings     = 0;

  masked_hamming_membership u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Output side: check accepted words, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] pick_mask();
    case ($urandom_range(7))
      0:       return ALL_ONES;
      1:       return '0;
      2:       return rand64() & rand64();
      3:       return rand64() | rand64();
      default: return rand64();
    endcase
  endfunction

  task automatic add_chunk(input logic [WORD_W-1:0] rb, rv, qb, qv, input bit lc, lt);
    stim_q.push_back('{rb, rv, qb, qv, lc, lt});
  endtask

  task automatic push_template(input int n, input code_style_e style, input bit dense,
                               input bit end_db);
    chunk_t c;
    for (int k = 0; k < n; k++) begin
      c.ref_bits = rand64();
      case (style)
        STYLE_NEAR:   c.query_bits = c.ref_bits ^ (rand64() & rand64() & rand64());
        STYLE_LOOSE:  c.query_bits = c.ref_bits ^ (rand64() & rand64());
        STYLE_INVERT: c.query_bits = ~c.ref_bits;
        default:      c.query_bits = rand64();
      endcase
      c.ref_valid     = dense ? ALL_ONES : pick_mask();
      c.query_valid   = dense ? ALL_ONES : pick_mask();
      c.last_chunk    = (k == n - 1);
      // a stray end-of-database flag on an inner chunk must be ignored
      c.last_template = (k == n - 1) ? end_db : ($urandom_range(9) == 0);
      stim_q.push_back(c);
    end
  endtask

  task automatic gen_database(input int n_items);
    int target, len, roll;
    target = stim_q.size() + n_items;
    while (stim_q.size() < target) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        len = $urandom_range(72, 65);
      end else if (roll < 15) begin
        len = $urandom_range(16, 5);
      end else begin
        len = $urandom_range(4, 1);
      end
      push_template(len, code_style_e'($urandom_range(3)),
                    (roll < 2) || ($urandom_range(9) == 0), $urandom_range(7) == 0);
    end
  endtask

  task automatic send_chunk(input chunk_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {c.query_valid, c.query_bits, c.ref_valid, c.ref_bits};
    s_axis_tlast  <= c.last_chunk;
    s_axis_tuser  <= c.last_template;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_chunk(c);
  endtask

  task automatic wait_results(input int extra);
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic play_stream(input bit pause_mid);
    int n;
    n = stim_q.size();
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i > 0 && i == n / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_results(0);
      end
      send_chunk(stim_q[i]);
    end
    stim_q.delete();
    s_axis_tvalid <= 1'b0;
  endtask

  // Write both registers on back-to-back edges; only call while drained.
  task automatic set_config(input logic [THR_W-1:0] thr, input logic [TPU_W-1:0] tpu);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    sb.write_reg(CFG_THRESHOLD, thr);
    cfg_idx_i  <= CFG_TPU;
    cfg_data_i <= {1'b0, tpu};
    @(posedge clk_i);
    sb.write_reg(CFG_TPU, {1'b0, tpu});
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [THR_W-1:0] thr_plan [N_PHASES];
    logic [TPU_W-1:0] tpu_plan [N_PHASES];
    int               src_mode [4];
    int               sink_mode [4];
    thr_plan  = '{8'd0, 8'd128, 8'd255, 8'd100, 8'd52, 8'd64, 8'd0, 8'd0};
    tpu_plan  = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd2, 7'd1, 7'd0, 7'd0};
    src_mode  = '{0, 81, 0, 25};
    sink_mode = '{0, 0, 81, 25};
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset defaults: threshold 52, one template per user.
    add_chunk('0, '0, '0, '0, 1, 0);                           // nothing valid
    add_chunk('0, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0);         // every bit differs
    add_chunk(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0);   // exact match
    add_chunk(ALL_ONES, ALL_ONES, '0, '0, 1, 1);               // query mask empty, db end
    add_chunk('0, ALL_ONES, 64'h3FF_FFFF, ALL_ONES, 1, 0);     // distance equals limit
    add_chunk('0, ALL_ONES, 64'h1FF_FFFF, ALL_ONES, 1, 0);     // one below limit
    add_chunk(rand64(), ALL_ONES, rand64(), ALL_ONES, 0, 1);   // stray db flag
    add_chunk(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, 1);
    add_chunk('0, {32{2'b10}}, ALL_ONES, {32{2'b01}}, 1, 0);   // disjoint masks
    add_chunk('0, ALL_ONES, ALL_ONES, 64'hFFFF_0000_FFFF_0000, 1, 1);
    play_stream(0);
    wait_results(DRAIN);

    // Partial group dropped at db end, then group size shrunk mid-group.
    set_config(8'd52, 7'd3);
    add_chunk(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0);
    add_chunk(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, 1);
    add_chunk('0, ALL_ONES, '0, ALL_ONES, 1, 0);
    add_chunk('0, ALL_ONES, '0, ALL_ONES, 1, 0);
    play_stream(0);
    wait_results(DRAIN);
    set_config(8'd52, 7'd1);
    add_chunk(rand64(), '0, rand64(), ALL_ONES, 0, 0);
    add_chunk('0, ALL_ONES, 64'h1, ALL_ONES, 1, 1);
    play_stream(0);
    wait_results(DRAIN);

    // Backpressure: hold the output while single-chunk templates pour in.
    set_config(8'd40, 7'd2);
    hold_asked <= hold_asked + 1;
    repeat (60) push_template(1, code_style_e'($urandom_range(3)), 0, 0);
    play_stream(0);
    wait_results(DRAIN);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p >= 6) begin
        set_config(THR_W'($urandom_range(255)), TPU_W'($urandom_range(127)));
      end else begin
        set_config(thr_plan[p], tpu_plan[p]);
      end
      src_idle_pct   = src_mode[p % 4];
      sink_stall_pct = sink_mode[p % 4];
      // saturate both counters once
      if (p == 0) push_template(70, STYLE_INVERT, 1, 0);
      gen_database(PHASE_LEN);
      play_stream(1);
      wait_results(DRAIN);
    end

    $display("Covered %0d chunks, %0d template verdicts (%0d matches, %0d saturated), %0d settings.",
             sb.n_chunks, sb.n_templates, sb.n_hits, sb.n_sat, n_settings);
    $display("Closed %0d user groups and %0d databases under four pacing modes and a long hold.",
             sb.n_users, sb.n_dbs);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
